// ----- sv/rational_arith_digit_capped_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the rational arithmetic block
// Shared wrappers so every checked module reports the same way.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITH_DIGIT_CAPPED_DEFINES_SVH
`define RATIONAL_ARITH_DIGIT_CAPPED_DEFINES_SVH

// Checked only outside reset
`define RAD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included
`define RAD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/rad_pkg.sv -----
// ----------------------------------------------------------------------------
// rad_pkg
// Types, codes and the power-of-ten table for the rational arithmetic block.
// ----------------------------------------------------------------------------
package rad_pkg;

  // operation codes
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [1:0] ST_ZERO_DEN  = 2'd2;

  localparam logic [3:0] DIGITS_RESET = 4'd4;
  localparam logic [3:0] DIGITS_LOW   = 4'd1;
  localparam logic [3:0] DIGITS_HIGH  = 4'd9;
  localparam logic [4:0] POW_LAST     = 5'd19;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] a_num;
    logic [31:0] a_den;
    logic [31:0] b_num;
    logic [31:0] b_den;
  } req_t;

  typedef struct packed {
    logic [63:0] res_num;
    logic [29:0] res_den;
    logic [1:0]  status;
  } res_t;

  // 10^i for i = 0..19
  function automatic logic [63:0] pow10(input logic [4:0] i);
    logic [63:0] p;
    p = 64'd1;
    unique case (i)
      5'd0:  p = 64'd1;
      5'd1:  p = 64'd10;
      5'd2:  p = 64'd100;
      5'd3:  p = 64'd1000;
      5'd4:  p = 64'd10000;
      5'd5:  p = 64'd100000;
      5'd6:  p = 64'd1000000;
      5'd7:  p = 64'd10000000;
      5'd8:  p = 64'd100000000;
      5'd9:  p = 64'd1000000000;
      5'd10: p = 64'd10000000000;
      5'd11: p = 64'd100000000000;
      5'd12: p = 64'd1000000000000;
      5'd13: p = 64'd10000000000000;
      5'd14: p = 64'd100000000000000;
      5'd15: p = 64'd1000000000000000;
      5'd16: p = 64'd10000000000000000;
      5'd17: p = 64'd100000000000000000;
      5'd18: p = 64'd1000000000000000000;
      5'd19: p = 64'd10000000000000000000;
      default: p = 64'd1;
    endcase
    return p;
  endfunction

endpackage

// ----- sv/rad_div.sv -----
// ----------------------------------------------------------------------------
// rad_div
// Restoring divider, 65-bit dividend by 64-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module rad_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        num_hi,
  input  logic [63:0] num_lo,
  input  logic [63:0] dvs,
  output logic        done,
  output logic [64:0] quo,
  output logic [63:0] rem
);
  localparam int DIV_STEPS = 65;

  logic [64:0] sh;
  logic [63:0] d;
  logic [6:0]  cnt;
  logic        run;
  logic [64:0] rs;
  logic [64:0] rn;
  logic        take;

  // one restoring step
  always_comb begin
    rs   = {rem, sh[64]};
    take = rs >= {1'b0, d};
    rn   = take ? rs - {1'b0, d} : rs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        sh  <= {num_hi, num_lo};
        d   <= dvs;
        rem <= '0;
        quo <= '0;
        cnt <= '0;
        run <= 1'b1;
      end else if (run) begin
        sh  <= {sh[63:0], 1'b0};
        rem <= rn[63:0];
        quo <= {quo[63:0], take};
        cnt <= cnt + 7'd1;
        if (cnt == 7'(DIV_STEPS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ----- sv/rad_gcd.sv -----
// ----------------------------------------------------------------------------
// rad_gcd
// Binary gcd of two 64-bit values, one shift or subtract per cycle.
// ----------------------------------------------------------------------------
module rad_gcd (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] x,
  input  logic [63:0] y,
  output logic        done,
  output logic [63:0] g
);
  logic [63:0] a;
  logic [63:0] b;
  logic [5:0]  sh;
  logic        run;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a   <= x;
        b   <= y;
        sh  <= '0;
        run <= 1'b1;
      end else if (run) begin
        priority if (a == '0) begin
          g    <= b << sh;
          run  <= 1'b0;
          done <= 1'b1;
        end else if (b == '0) begin
          g    <= a << sh;
          run  <= 1'b0;
          done <= 1'b1;
        end else if (!a[0] && !b[0]) begin
          a  <= a >> 1;
          b  <= b >> 1;
          sh <= sh + 6'd1;
        end else if (!a[0]) begin
          a <= a >> 1;
        end else if (!b[0]) begin
          b <= b >> 1;
        end else if (a >= b) begin
          a <= (a - b) >> 1;
        end else begin
          b <= (b - a) >> 1;
        end
      end
    end
  end
endmodule

// ----- sv/rational_arith_digit_capped.sv -----
// ----------------------------------------------------------------------------
// rational_arith_digit_capped
// Adds, subtracts, multiplies or divides two fractions, reduces the result
// and caps the denominator at max_digits (clamped to 1..9) decimal digits.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; busy stays high
// until the result is shown. The result appears for exactly one cycle with
// done high and cannot be held off, so capture it on that edge. A
// transaction runs from the accepting edge to the done edge through four
// multiplier states and a forming state, then a reduction (three passes of
// the 65-step bit-serial divider plus a binary gcd), a digit count and a
// decision state, and, when the denominator is too long, two more divider
// passes and a second reduction, then an output state. Errors (underflow,
// zero denominator) return from the forming state.
module rational_arith_digit_capped (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  rad_pkg::req_t req,
  output logic          done,
  output rad_pkg::res_t res,
  input  logic          cfg_we,
  input  logic [3:0]    cfg_data
);
  import rad_pkg::*;
  `include "rational_arith_digit_capped_defines.svh"

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_MUL0   = 5'd1;
  localparam logic [4:0] S_MUL1   = 5'd2;
  localparam logic [4:0] S_MUL2   = 5'd3;
  localparam logic [4:0] S_MUL3   = 5'd4;
  localparam logic [4:0] S_FORM   = 5'd5;
  localparam logic [4:0] S_L1_GO  = 5'd6;
  localparam logic [4:0] S_L1_W   = 5'd7;
  localparam logic [4:0] S_GCD_GO = 5'd8;
  localparam logic [4:0] S_GCD_W  = 5'd9;
  localparam logic [4:0] S_L2_GO  = 5'd10;
  localparam logic [4:0] S_L2_W   = 5'd11;
  localparam logic [4:0] S_L3_GO  = 5'd12;
  localparam logic [4:0] S_L3_W   = 5'd13;
  localparam logic [4:0] S_DIG    = 5'd14;
  localparam logic [4:0] S_K      = 5'd15;
  localparam logic [4:0] S_SD_GO  = 5'd16;
  localparam logic [4:0] S_SD_W   = 5'd17;
  localparam logic [4:0] S_SN_GO  = 5'd18;
  localparam logic [4:0] S_SN_W   = 5'd19;
  localparam logic [4:0] S_OUT    = 5'd20;

  logic [4:0]  state;
  logic [3:0]  max_digits;
  req_t        rq;
  logic [63:0] p1, p2, pd, pm;
  logic        hi;
  logic [63:0] lo, den, rr, g, pw;
  logic [4:0]  nd, idx;
  logic        pass2;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic        div_start, div_hi, div_done;
  logic [63:0] div_lo, div_d, div_rem;
  logic [64:0] div_quo, sum65, quo_up;
  logic        gcd_start, gcd_done;
  logic [63:0] gcd_g;
  logic [3:0]  m_clamp;
  logic [4:0]  k;

  rad_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num_hi(div_hi), .num_lo(div_lo),
    .dvs(div_d), .done(div_done), .quo(div_quo), .rem(div_rem)
  );

  rad_gcd u_gcd (
    .clk(clk), .rst(rst), .start(gcd_start), .x(den), .y(rr),
    .done(gcd_done), .g(gcd_g)
  );

  assign busy = (state != S_IDLE);

  // shared multiplier operand select
  always_comb begin
    mul_a = rq.a_num;
    mul_b = rq.b_den;
    unique case (state)
      S_MUL1:  begin mul_a = rq.b_num; mul_b = rq.a_den; end
      S_MUL2:  begin
        mul_a = rq.a_den;
        mul_b = (rq.req_type == OP_DIV) ? rq.b_num : rq.b_den;
      end
      S_MUL3:  begin mul_a = rq.a_num; mul_b = rq.b_num; end
      default: begin mul_a = rq.a_num; mul_b = rq.b_den; end
    endcase
    mul_p = {32'd0, mul_a} * {32'd0, mul_b};
  end

  // divider and gcd launch
  always_comb begin
    div_start = 1'b0;
    div_hi    = hi;
    div_lo    = lo;
    div_d     = den;
    gcd_start = (state == S_GCD_GO);
    unique case (state)
      S_L1_GO: div_start = 1'b1;
      S_L2_GO: begin div_start = 1'b1; div_d = g; end
      S_L3_GO: begin div_start = 1'b1; div_hi = 1'b0; div_lo = den; div_d = g; end
      S_SD_GO: begin div_start = 1'b1; div_hi = 1'b0; div_lo = den; div_d = pw; end
      S_SN_GO: begin div_start = 1'b1; div_d = pw; end
      default: div_start = 1'b0;
    endcase
  end

  // digit cap arithmetic
  always_comb begin
    sum65   = {1'b0, p1} + {1'b0, p2};
    quo_up  = div_quo + 65'(div_rem != '0);
    m_clamp = max_digits;
    if (max_digits < DIGITS_LOW) m_clamp = DIGITS_LOW;
    if (max_digits > DIGITS_HIGH) m_clamp = DIGITS_HIGH;
    k = nd - {1'b0, m_clamp};
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_digits <= DIGITS_RESET;
    end else if (cfg_we) begin
      max_digits <= cfg_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            rq    <= req;
            pass2 <= 1'b0;
            state <= S_MUL0;
          end
        end
        S_MUL0: begin p1 <= mul_p; state <= S_MUL1; end
        S_MUL1: begin p2 <= mul_p; state <= S_MUL2; end
        S_MUL2: begin pd <= mul_p; state <= S_MUL3; end
        S_MUL3: begin pm <= mul_p; state <= S_FORM; end
        S_FORM: begin
          den <= pd;
          // only a sum can carry into the 65th bit
          hi  <= (rq.req_type == OP_ADD) ? sum65[64] : 1'b0;
          unique case (rq.req_type)
            OP_ADD:  lo <= sum65[63:0];
            OP_SUB:  lo <= p1 - p2;
            OP_MUL:  lo <= pm;
            default: lo <= p1;
          endcase
          // zero denominator is checked ahead of underflow
          if (pd == '0) begin
            res   <= '{res_num: 64'd0, res_den: 30'd1, status: ST_ZERO_DEN};
            done  <= 1'b1;
            state <= S_IDLE;
          end else if (rq.req_type == OP_SUB && p1 < p2) begin
            res   <= '{res_num: 64'd0, res_den: 30'd1, status: ST_UNDERFLOW};
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_L1_GO;
          end
        end
        // reduction: remainder, gcd, then divide both terms by it
        S_L1_GO: state <= S_L1_W;
        S_L1_W: begin
          if (div_done) begin rr <= div_rem; state <= S_GCD_GO; end
        end
        S_GCD_GO: state <= S_GCD_W;
        S_GCD_W: begin
          if (gcd_done) begin g <= gcd_g; state <= S_L2_GO; end
        end
        S_L2_GO: state <= S_L2_W;
        S_L2_W: begin
          if (div_done) begin
            hi    <= div_quo[64];
            lo    <= div_quo[63:0];
            state <= S_L3_GO;
          end
        end
        S_L3_GO: state <= S_L3_W;
        S_L3_W: begin
          if (div_done) begin
            den <= div_quo[63:0];
            nd  <= 5'd1;
            idx <= 5'd1;
            state <= pass2 ? S_OUT : S_DIG;
          end
        end
        // count decimal digits of the denominator
        S_DIG: begin
          if (den >= pow10(idx)) nd <= nd + 5'd1;
          idx <= idx + 5'd1;
          if (idx == POW_LAST) state <= S_K;
        end
        S_K: begin
          if (nd > {1'b0, m_clamp}) begin
            pw    <= pow10(k);
            state <= S_SD_GO;
          end else begin
            state <= S_OUT;
          end
        end
        S_SD_GO: state <= S_SD_W;
        S_SD_W: begin
          if (div_done) begin den <= div_quo[63:0]; state <= S_SN_GO; end
        end
        S_SN_GO: state <= S_SN_W;
        S_SN_W: begin
          if (div_done) begin
            hi    <= quo_up[64];
            lo    <= quo_up[63:0];
            pass2 <= 1'b1;
            state <= S_L1_GO;
          end
        end
        S_OUT: begin
          res.res_num <= hi ? '1 : lo;
          res.res_den <= den[29:0];
          res.status  <= ST_OK;
          done        <= 1'b1;
          state       <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `RAD_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted transaction did not raise busy")
  `RAD_ASSERT(a_done_ends, done |-> !busy, "result shown while still busy")
  `RAD_ASSERT(a_err_zero, (done && res.status != ST_OK) |-> (res.res_num == '0 && res.res_den == 30'd1), "error result is not 0/1")
  `RAD_ASSERT_ALWAYS(a_den_nonzero, done |-> res.res_den != '0, "zero result denominator")
endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: rational arithmetic block testbench
// Drives add/subtract/multiply/divide transactions on two fractions, predicts
// the reduced and digit-capped result of each one, and checks every result
// field against the prediction under several max_digits settings.
// ----------------------------------------------------------------------------
module tb_top;
  import rad_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  req_t       req = '0;
  logic       done;
  res_t       res;
  logic       cfg_we = 1'b0;
  logic [3:0] cfg_data = DIGITS_RESET;

  req_t       pend_reqs[$];     // transactions waiting to be driven
  res_t       ratio_due[$];     // predicted results not yet seen
  logic [3:0] digits_cfg = DIGITS_RESET;
  logic       calm = 1'b0;      // no sender gaps while set
  int         mismatches = 0;

  rational_arith_digit_capped dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req      (req),
    .done     (done),
    .res      (res),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  // Euclid on 65-bit values; b starts nonzero
  function automatic logic [64:0] gcd65(logic [64:0] a, logic [64:0] b);
    logic [64:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // Expected result of one transaction under a given max_digits
  function automatic res_t ratio_predict(req_t r, logic [3:0] md);
    logic [63:0] p1, p2, den, pw, v;
    logic [64:0] num, g, rem;
    logic [1:0]  st;
    int          nd, m;
    res_t        o;
    p1  = 64'(r.a_num) * 64'(r.b_den);
    p2  = 64'(r.b_num) * 64'(r.a_den);
    num = '0;
    st  = ST_OK;
    den = 64'(r.a_den) * 64'(r.b_den);
    case (r.req_type)
      OP_ADD: num = {1'b0, p1} + {1'b0, p2};
      OP_SUB: begin
        if (den != 0 && p1 < p2) st = ST_UNDERFLOW;
        else num = {1'b0, p1 - p2};
      end
      OP_MUL: num = {1'b0, 64'(r.a_num) * 64'(r.b_num)};
      default: begin
        num = {1'b0, p1};
        den = 64'(r.a_den) * 64'(r.b_num);
      end
    endcase
    if (den == 0) st = ST_ZERO_DEN;
    if (st != ST_OK) begin
      o.res_num = '0;
      o.res_den = 30'd1;
      o.status  = st;
      return o;
    end
    m = md;
    if (m < DIGITS_LOW) m = DIGITS_LOW;
    if (m > DIGITS_HIGH) m = DIGITS_HIGH;
    // lowest terms
    g   = gcd65(num, {1'b0, den});
    num = num / g;
    den = den / g[63:0];
    nd = 0;
    for (v = den; v != 0; v = v / 10) nd++;
    // too many digits: floor the denominator, ceiling the numerator
    if (nd > m) begin
      pw = 64'd1;
      for (int j = 0; j < nd - m; j++) pw = pw * 10;
      den = den / pw;
      rem = num % {1'b0, pw};
      num = num / {1'b0, pw} + 65'(rem != 0);
      g   = gcd65(num, {1'b0, den});
      num = num / g;
      den = den / g[63:0];
    end
    o.res_num = num[64] ? '1 : num[63:0];
    o.res_den = den[29:0];
    o.status  = ST_OK;
    return o;
  endfunction

  // Driver: one transaction per accept, random sender gaps
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) ratio_due = {ratio_due, ratio_predict(req, digits_cfg)};
      if (pend_reqs.size() > 0 && (calm || $urandom_range(0, 99) >= 18)) begin
        start <= 1'b1;
        req   <= pend_reqs.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: results cannot be held off, take each on its strobe
  always @(posedge clk) begin
    if (!rst && done) begin
      if (ratio_due.size() == 0) begin
        $display("%0t: result with nothing expected: num=%h den=%0d st=%0d",
                 $time, res.res_num, res.res_den, res.status);
        mismatches++;
      end else begin
        res_t e;
        e = ratio_due.pop_front();
        if (res.res_num !== e.res_num || res.res_den !== e.res_den ||
            res.status !== e.status) begin
          $display("%0t: mismatch exp num=%h den=%0d st=%0d got num=%h den=%0d st=%0d",
                   $time, e.res_num, e.res_den, e.status,
                   res.res_num, res.res_den, res.status);
          mismatches++;
        end
      end
    end
  end

  function automatic req_t mk_req(logic [1:0] op, logic [31:0] an, logic [31:0] ad,
                                  logic [31:0] bn, logic [31:0] bd);
    req_t r;
    r.req_type = op;
    r.a_num = an;
    r.a_den = ad;
    r.b_num = bn;
    r.b_den = bd;
    return r;
  endfunction

  // Append one transaction to the pending list
  task automatic add_req(req_t r);
    pend_reqs = {pend_reqs, r};
  endtask

  // Operand mix: zeros, all ones, narrow values and full-width values
  function automatic logic [31:0] rnd_word(bit is_den);
    logic [31:0] w;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < (is_den ? 2 : 5)) w = '0;
    else if (sel < 9) w = '1;
    else if (sel < 45) w = $urandom & 32'((64'd1 << $urandom_range(1, 32)) - 64'd1);
    else if (sel < 70) w = $urandom >> $urandom_range(0, 31);
    else w = $urandom;
    return w;
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (pend_reqs.size() != 0 || start || ratio_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_digits(logic [3:0] v);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    digits_cfg = v;
  endtask

  // Stimulus
  initial begin
    logic [3:0] phase_digits[9];
    phase_digits = '{4'd9, 4'd1, 4'd0, 4'd15, 4'd6, 4'd3, 4'd12, 4'd9, 4'd4};
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, every operation, error and rounding cases
    add_req(mk_req(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3));
    add_req(mk_req(OP_SUB, 32'd3, 32'd4, 32'd1, 32'd4));
    add_req(mk_req(OP_MUL, 32'd2, 32'd3, 32'd3, 32'd4));
    add_req(mk_req(OP_DIV, 32'd2, 32'd3, 32'd4, 32'd9));
    add_req(mk_req(OP_SUB, 32'd1, 32'd4, 32'd3, 32'd4));   // underflow
    add_req(mk_req(OP_SUB, 32'd0, 32'd1, '1, 32'd1));      // underflow
    add_req(mk_req(OP_DIV, 32'd5, 32'd7, 32'd0, 32'd3));   // zero divisor
    add_req(mk_req(OP_ADD, 32'd5, 32'd0, 32'd1, 32'd3));   // zero denominator
    add_req(mk_req(OP_SUB, 32'd5, 32'd3, 32'd9, 32'd0));   // zero den wins over underflow
    add_req(mk_req(OP_MUL, 32'd1, 32'd0, 32'd0, 32'd0));
    add_req(mk_req(OP_MUL, 32'd0, 32'd7, 32'd5, 32'd9));   // zero numerator
    add_req(mk_req(OP_SUB, 32'd5, 32'd9, 32'd5, 32'd9));   // equal, zero result
    add_req(mk_req(OP_ADD, '1, '1, '1, '1));               // wide sum
    add_req(mk_req(OP_ADD, '1, 32'd1, '1, 32'd1));         // 33-bit numerator
    add_req(mk_req(OP_MUL, '1, 32'd1, '1, 32'd1));
    add_req(mk_req(OP_DIV, '1, 32'd1, 32'd1, '1));
    add_req(mk_req(OP_MUL, 32'd1, '1, 32'd1, '1));         // 20-digit denominator
    add_req(mk_req(OP_ADD, 32'd1, 32'd99991, 32'd1, 32'd99989));
    add_req(mk_req(OP_MUL, 32'd1, 32'd3, 32'd1, 32'd3));   // exact, no rounding
    add_req(mk_req(OP_DIV, 32'd7, 32'd1000003, 32'd1, 32'd1));
    add_req(mk_req(OP_SUB, '1, 32'd1, 32'd0, '1));
    add_req(mk_req(OP_DIV, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h7fff_ffff));
    wait_idle();

    // random phases, each under its own digit cap
    for (int ph = 0; ph < 9; ph++) begin
      set_digits(phase_digits[ph]);
      calm = (ph == 0);
      for (int i = 0; i < 205; i++)
        add_req(mk_req(2'($urandom_range(0, 3)), rnd_word(1'b0),
                       rnd_word(1'b1), rnd_word(1'b0), rnd_word(1'b1)));
      wait_idle();
    end

    repeat (900) @(negedge clk);
    if (mismatches == 0 && ratio_due.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #200_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
